/* rtl/mfh_pkg.sv */
package mfh_pkg;

	// Header field codes.
	localparam logic [10:0] SYNC_BITS    = 11'h7FF;
	localparam logic [1:0]  VER_MPEG25   = 2'd0;
	localparam logic [1:0]  VER_RESERVED = 2'd1;
	localparam logic [1:0]  VER_MPEG2    = 2'd2;
	localparam logic [1:0]  VER_MPEG1    = 2'd3;
	localparam logic [1:0]  LAYER_III    = 2'd1;
	localparam logic [3:0]  BR_FREE      = 4'd0;
	localparam logic [3:0]  BR_BAD       = 4'd15;
	localparam logic [1:0]  SR_44K       = 2'd0;
	localparam logic [1:0]  SR_48K       = 2'd1;
	localparam logic [1:0]  SR_32K       = 2'd2;
	localparam logic [1:0]  SR_RESERVED  = 2'd3;
	localparam logic [1:0]  MODE_MONO    = 2'd3;

	// Output constants.
	localparam logic [17:0] NUMER_V1       = 18'd144000;
	localparam logic [17:0] NUMER_V2       = 18'd72000;
	localparam logic [10:0] MIN_FRAME      = 11'd24;
	localparam logic [10:0] SPF_V1         = 11'd1152;
	localparam logic [10:0] SPF_V2         = 11'd576;
	localparam logic [5:0]  SIDE_V1_MONO   = 6'd17;
	localparam logic [5:0]  SIDE_V1_STEREO = 6'd32;
	localparam logic [5:0]  SIDE_V2_MONO   = 6'd9;
	localparam logic [5:0]  SIDE_V2_STEREO = 6'd17;
	localparam logic [1:0]  CHANS_MONO     = 2'd1;
	localparam logic [1:0]  CHANS_STEREO   = 2'd2;

	// Datapath widths of the frame size division.
	localparam int NUMER_W = 26;
	localparam int RECIP_W = 20;
	localparam int PROD_W  = NUMER_W + RECIP_W;
	localparam int QUOT_W  = 11;
	localparam int RECIP_SHIFT = 32;
	localparam int QR_W    = 27;

	// Decoded header fields that travel down the pipeline.
	typedef struct packed {
		logic        fields_ok;
		logic [15:0] rate;
		logic [8:0]  kbps;
		logic        v1;
		logic        pad;
		logic [1:0]  chans;
		logic [1:0]  ver;
		logic        crc;
		logic [5:0]  side;
	} hdr_info_t;

	// Bitrate in kbit/s from the bitrate index.
	function automatic logic [8:0] kbps_lookup(input logic v1, input logic [3:0] idx);
		logic [8:0] k;
		k = 9'd0;
		if (v1) begin
			case (idx)
				4'd1:    k = 9'd32;
				4'd2:    k = 9'd40;
				4'd3:    k = 9'd48;
				4'd4:    k = 9'd56;
				4'd5:    k = 9'd64;
				4'd6:    k = 9'd80;
				4'd7:    k = 9'd96;
				4'd8:    k = 9'd112;
				4'd9:    k = 9'd128;
				4'd10:   k = 9'd160;
				4'd11:   k = 9'd192;
				4'd12:   k = 9'd224;
				4'd13:   k = 9'd256;
				4'd14:   k = 9'd320;
				default: k = 9'd0;
			endcase
		end else begin
			case (idx)
				4'd1:    k = 9'd8;
				4'd2:    k = 9'd16;
				4'd3:    k = 9'd24;
				4'd4:    k = 9'd32;
				4'd5:    k = 9'd40;
				4'd6:    k = 9'd48;
				4'd7:    k = 9'd56;
				4'd8:    k = 9'd64;
				4'd9:    k = 9'd80;
				4'd10:   k = 9'd96;
				4'd11:   k = 9'd112;
				4'd12:   k = 9'd128;
				4'd13:   k = 9'd144;
				4'd14:   k = 9'd160;
				default: k = 9'd0;
			endcase
		end
		return k;
	endfunction

	// MPEG-1 sample rate in Hz.
	function automatic logic [15:0] base_rate(input logic [1:0] sr);
		logic [15:0] r;
		case (sr)
			SR_44K:  r = 16'd44100;
			SR_48K:  r = 16'd48000;
			SR_32K:  r = 16'd32000;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	// floor(2^32 / rate) for every legal rate.
	function automatic logic [RECIP_W-1:0] recip_lookup(input logic [1:0] ver,
			input logic [1:0] sr);
		logic [RECIP_W-1:0] r;
		case ({ver, sr})
			{VER_MPEG1, SR_44K}:  r = 20'd97391;
			{VER_MPEG1, SR_48K}:  r = 20'd89478;
			{VER_MPEG1, SR_32K}:  r = 20'd134217;
			{VER_MPEG2, SR_44K}:  r = 20'd194783;
			{VER_MPEG2, SR_48K}:  r = 20'd178956;
			{VER_MPEG2, SR_32K}:  r = 20'd268435;
			{VER_MPEG25, SR_44K}: r = 20'd389566;
			{VER_MPEG25, SR_48K}: r = 20'd357913;
			{VER_MPEG25, SR_32K}: r = 20'd536870;
			default:              r = 20'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/mfh_in_if.sv */
interface mfh_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] header_word;

	modport source(output valid, output header_word, input ready);
	modport sink(input valid, input header_word, output ready);
endinterface

/* rtl/mfh_out_if.sv */
interface mfh_out_if;
	logic        valid;
	logic        ready;
	logic        valid_res;
	logic [15:0] sample_rate;
	logic [8:0]  bit_rate;
	logic [10:0] frame_len;
	logic [10:0] frame_samples;
	logic [1:0]  channel_count;
	logic [1:0]  version_code;
	logic        crc_present;
	logic [5:0]  side_info_bytes;

	modport source(output valid, output valid_res, output sample_rate,
		output bit_rate, output frame_len, output frame_samples,
		output channel_count, output version_code, output crc_present,
		output side_info_bytes, input ready);
	modport sink(input valid, input valid_res, input sample_rate,
		input bit_rate, input frame_len, input frame_samples,
		input channel_count, input version_code, input crc_present,
		input side_info_bytes, output ready);
endinterface

/* rtl/mfh_decode.sv */
module mfh_decode (
	input  logic                              clk,
	input  logic                              arst_n,
	mfh_in_if.sink                            hdr,
	output logic                              valid_s1,
	input  logic                              ready_s1,
	output mfh_pkg::hdr_info_t                info_s1,
	output logic [mfh_pkg::NUMER_W-1:0]       numer_s1,
	output logic [mfh_pkg::RECIP_W-1:0]       recip_s1
);
	import mfh_pkg::*;

	logic [31:0]         w;
	logic [1:0]          ver;
	logic [1:0]          sr;
	logic [3:0]          br;
	logic                v1;
	logic [17:0]         numer_k;
	logic [NUMER_W-1:0]  numer_full;
	hdr_info_t           info;

	assign w = hdr.header_word;
	assign ver = w[20:19];
	assign sr  = w[11:10];
	assign br  = w[15:12];
	assign v1  = (ver == VER_MPEG1);

	// Field checks and table lookups.
	always_comb begin
		info.fields_ok = (w[31:21] == SYNC_BITS) && (ver != VER_RESERVED) &&
			(w[18:17] == LAYER_III) && (br != BR_FREE) && (br != BR_BAD) &&
			(sr != SR_RESERVED);
		case (ver)
			VER_MPEG1: info.rate = base_rate(sr);
			VER_MPEG2: info.rate = base_rate(sr) >> 1;
			default:   info.rate = base_rate(sr) >> 2;
		endcase
		info.kbps  = kbps_lookup(v1, br);
		info.v1    = v1;
		info.pad   = w[9];
		info.chans = (w[7:6] == MODE_MONO) ? CHANS_MONO : CHANS_STEREO;
		info.ver   = ver;
		info.crc   = ~w[16];
		if (v1) begin
			info.side = (w[7:6] == MODE_MONO) ? SIDE_V1_MONO : SIDE_V1_STEREO;
		end else begin
			info.side = (w[7:6] == MODE_MONO) ? SIDE_V2_MONO : SIDE_V2_STEREO;
		end
	end

	// Frame size numerator: 144000 or 72000 times the bitrate.
	assign numer_k    = v1 ? NUMER_V1 : NUMER_V2;
	assign numer_full = {{(NUMER_W-18){1'b0}}, numer_k} * {{(NUMER_W-9){1'b0}}, info.kbps};

	assign hdr.ready = !valid_s1 || ready_s1;

	// Stage 1 valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr.ready) begin
			valid_s1 <= hdr.valid;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (hdr.valid && hdr.ready) begin
			info_s1  <= info;
			numer_s1 <= numer_full;
			recip_s1 <= recip_lookup(ver, sr);
		end
	end

endmodule

/* rtl/mfh_frame_div.sv */
module mfh_frame_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_s1,
	output logic                              ready_s1,
	input  mfh_pkg::hdr_info_t                info_s1,
	input  logic [mfh_pkg::NUMER_W-1:0]       numer_s1,
	input  logic [mfh_pkg::RECIP_W-1:0]       recip_s1,
	output logic                              valid_s3,
	input  logic                              ready_s3,
	output mfh_pkg::hdr_info_t                info_s3,
	output logic [mfh_pkg::NUMER_W-1:0]       numer_s3,
	output logic [mfh_pkg::QUOT_W-1:0]        quot_s3,
	output logic [mfh_pkg::QR_W-1:0]          qr_s3
);
	import mfh_pkg::*;

	logic                valid_s2;
	logic                ready_s2;
	hdr_info_t           info_s2;
	logic [NUMER_W-1:0]  numer_s2;
	logic [QUOT_W-1:0]   quot_s2;
	logic [PROD_W-1:0]   prod;
	logic [QR_W-1:0]     qr;

	assign ready_s2 = !valid_s3 || ready_s3;
	assign ready_s1 = !valid_s2 || ready_s2;

	// Quotient estimate by reciprocal; it is the true quotient or one less.
	assign prod = {{(PROD_W-NUMER_W){1'b0}}, numer_s1} * {{(PROD_W-RECIP_W){1'b0}}, recip_s1};
	// Back-multiply the estimate for the remainder check.
	assign qr = {{(QR_W-QUOT_W){1'b0}}, quot_s2} * {{(QR_W-16){1'b0}}, info_s2.rate};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s2) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Stage 2 and stage 3 payload.
	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s1) begin
			info_s2  <= info_s1;
			numer_s2 <= numer_s1;
			quot_s2  <= prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
		end
		if (valid_s2 && ready_s2) begin
			info_s3  <= info_s2;
			numer_s3 <= numer_s2;
			quot_s3  <= quot_s2;
			qr_s3    <= qr;
		end
	end

endmodule

/* rtl/mfh_result.sv */
module mfh_result (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_s3,
	output logic                              ready_s3,
	input  mfh_pkg::hdr_info_t                info_s3,
	input  logic [mfh_pkg::NUMER_W-1:0]       numer_s3,
	input  logic [mfh_pkg::QUOT_W-1:0]        quot_s3,
	input  logic [mfh_pkg::QR_W-1:0]          qr_s3,
	mfh_out_if.source                         res
);
	import mfh_pkg::*;

	logic                valid_s4;
	logic [QR_W-1:0]     rem;
	logic                bump;
	logic [QUOT_W-1:0]   fsize;
	logic                ok;

	// Remainder correction, padding and the minimum size check.
	assign rem   = {{(QR_W-NUMER_W){1'b0}}, numer_s3} - qr_s3;
	assign bump  = (rem >= {{(QR_W-16){1'b0}}, info_s3.rate});
	assign fsize = quot_s3 + {{(QUOT_W-1){1'b0}}, bump} + {{(QUOT_W-1){1'b0}}, info_s3.pad};
	assign ok    = info_s3.fields_ok && (fsize >= MIN_FRAME);

	assign ready_s3  = !valid_s4 || res.ready;
	assign res.valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s3) begin
			valid_s4 <= valid_s3;
		end
	end

	// Output register; every field is zero for a rejected header.
	always_ff @(posedge clk) begin
		if (valid_s3 && ready_s3) begin
			res.valid_res       <= ok;
			res.sample_rate     <= ok ? info_s3.rate : 16'd0;
			res.bit_rate        <= ok ? info_s3.kbps : 9'd0;
			res.frame_len       <= ok ? fsize : 11'd0;
			res.frame_samples   <= ok ? (info_s3.v1 ? SPF_V1 : SPF_V2) : 11'd0;
			res.channel_count   <= ok ? info_s3.chans : 2'd0;
			res.version_code    <= ok ? info_s3.ver : 2'd0;
			res.crc_present     <= ok && info_s3.crc;
			res.side_info_bytes <= ok ? info_s3.side : 6'd0;
		end
	end

endmodule

/* rtl/mp3_frame_header_decode.sv */
// Channel | Role   | Handshake     | Payload
// hdr     | sink   | valid / ready | header_word (32 bits)
// res     | source | valid / ready | valid_res and eight decoded header fields
//
// One header item enters per cycle while res does not stall; its result is on res
// once the item has been accepted and reaches the fourth register stage.
// The stages are set by the frame size division: a reciprocal multiply, a
// back-multiply and a remainder correction, each in a stage of its own.
// Reset clears the valid bit of every stage; no payload register is reset.
// A stall on res holds only the stages that are full, so empty stages fill.
module mp3_frame_header_decode (
	input  logic       clk,
	input  logic       arst_n,
	mfh_in_if.sink     hdr,
	mfh_out_if.source  res
);
	import mfh_pkg::*;

	logic                valid_s1;
	logic                ready_s1;
	hdr_info_t           info_s1;
	logic [NUMER_W-1:0]  numer_s1;
	logic [RECIP_W-1:0]  recip_s1;
	logic                valid_s3;
	logic                ready_s3;
	hdr_info_t           info_s3;
	logic [NUMER_W-1:0]  numer_s3;
	logic [QUOT_W-1:0]   quot_s3;
	logic [QR_W-1:0]     qr_s3;

	// Field decode and table lookups.
	mfh_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.hdr      (hdr),
		.valid_s1 (valid_s1),
		.ready_s1 (ready_s1),
		.info_s1  (info_s1),
		.numer_s1 (numer_s1),
		.recip_s1 (recip_s1)
	);

	// Frame size quotient estimate.
	mfh_frame_div u_frame_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.ready_s1 (ready_s1),
		.info_s1  (info_s1),
		.numer_s1 (numer_s1),
		.recip_s1 (recip_s1),
		.valid_s3 (valid_s3),
		.ready_s3 (ready_s3),
		.info_s3  (info_s3),
		.numer_s3 (numer_s3),
		.quot_s3  (quot_s3),
		.qr_s3    (qr_s3)
	);

	// Correction, final checks and the output register.
	mfh_result u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s3 (valid_s3),
		.ready_s3 (ready_s3),
		.info_s3  (info_s3),
		.numer_s3 (numer_s3),
		.quot_s3  (quot_s3),
		.qr_s3    (qr_s3),
		.res      (res)
	);

endmodule
